[rtl/core/psp_pkg.sv]
// shared types and constants for the positional sound pan and doppler block
`timescale 1ns / 1ps

package psp_pkg;

    localparam int D_W        = 17;  // source minus listener
    localparam int SQP_W      = 33;  // one squared component
    localparam int SQ_W       = 34;  // squared distance
    localparam int RAD_W      = 50;  // squared distance with 16 fraction bits
    localparam int D8_W       = 25;  // distance with 8 fraction bits
    localparam int AXP_W      = 33;  // axis component times offset
    localparam int DOT_W      = 35;  // axis dot product
    localparam int ABS_W      = 34;  // magnitude of an axis dot product
    localparam int VP_W       = 49;  // velocity component times offset
    localparam int VDOT_W     = 51;  // radial speed term
    localparam int VMAG_W     = 50;
    localparam int DIST_W     = 17;
    localparam int QUO_W      = 13;  // quotient bits of every divider
    localparam int PAN_NUM_W  = 41;
    localparam int DOP_NUM_W  = 58;
    localparam int DOP_DEN_W  = 35;
    localparam int GAIN_NUM_W = 25;
    localparam int MAXD_W     = 15;
    localparam int FACTOR_W   = 15;
    localparam int DELTA_W    = 14;

    localparam logic [8:0]             NONE_ID      = 9'd255;
    localparam logic [6:0]             PAN_LEFT     = 7'd0;
    localparam logic [6:0]             PAN_CENTER   = 7'd64;
    localparam logic [6:0]             PAN_RIGHT    = 7'd127;
    localparam logic [DOP_DEN_W-1:0]   DOP_SCALE    = 35'd600;
    localparam logic [FACTOR_W-1:0]    FACTOR_ONE   = 15'd16384;
    localparam logic [DELTA_W-1:0]     DELTA_MAX    = 14'd8192;
    localparam logic [8:0]             GAIN_FULL    = 9'd256;

    typedef enum logic [2:0] {
        CFG_LISTENER_X = 3'd0,
        CFG_LISTENER_Y = 3'd1,
        CFG_LISTENER_Z = 3'd2,
        CFG_FRONT_AXIS = 3'd3,
        CFG_SIDE_AXIS  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [8:0]         sound_id;
        logic [14:0]        volume_in;
        logic [15:0]        pitch_in;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic signed [15:0] src_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [14:0]        max_distance;
        logic               doppler_enable;
        logic signed [15:0] priority_tag;
    } trig_t;

    typedef struct packed {
        logic [8:0]         sound_out;
        logic [6:0]         pan;
        logic [15:0]        pitch_out;
        logic [14:0]        volume_out;
        logic signed [15:0] tag_out;
    } res_t;

endpackage

[rtl/core/psp_delay.sv]
// delay line that carries payload and valid bits alongside the arithmetic units
`timescale 1ns / 1ps

module psp_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  logic [WIDTH-1:0] data,
    output logic             valid_out,
    output logic [WIDTH-1:0] data_out
);

    logic             valid_reg [DEPTH];
    logic [WIDTH-1:0] data_reg  [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= data;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign valid_out = valid_reg[DEPTH-1];
    assign data_out  = data_reg[DEPTH-1];

endmodule

[rtl/core/psp_isqrt.sv]
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module psp_isqrt #(
    parameter int IN_W = 50
) (
    input  logic                clk,
    input  logic                en,
    input  logic [IN_W-1:0]     radicand,
    output logic [IN_W/2-1:0]   root
);

    localparam int OUT_W = IN_W / 2;
    localparam int NW    = IN_W + 1;

    logic [NW-1:0] n_reg [OUT_W];
    logic [NW-1:0] r_reg [OUT_W];
    logic [NW-1:0] n_in  [OUT_W];
    logic [NW-1:0] r_in  [OUT_W];

    genvar s;
    generate
        for (s = 0; s < OUT_W; s++)
        begin : g_stage
            logic [NW-1:0] bit_w;
            logic [NW-1:0] trial;
            logic [NW-1:0] n_next;
            logic [NW-1:0] r_next;

            if (s == 0)
            begin : g_first
                assign n_in[s] = NW'(radicand);
                assign r_in[s] = '0;
            end
            else
            begin : g_rest
                assign n_in[s] = n_reg[s-1];
                assign r_in[s] = r_reg[s-1];
            end

            assign bit_w = NW'(1) << (2 * (OUT_W - 1 - s));
            assign trial = r_in[s] + bit_w;

            always_comb
            begin
                if (n_in[s] >= trial)
                begin
                    n_next = n_in[s] - trial;
                    r_next = (r_in[s] >> 1) + bit_w;
                end
                else
                begin
                    n_next = n_in[s];
                    r_next = r_in[s] >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[s] <= n_next;
                    r_reg[s] <= r_next;
                end
            end
        end
    endgenerate

    assign root = r_reg[OUT_W-1][OUT_W-1:0];

endmodule

[rtl/core/psp_udiv.sv]
// pipelined restoring unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps

module psp_udiv #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int QUO_W = 8
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    // quotient must fit in QUO_W bits for an exact result
    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     rem_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [W-1:0]     rem_in  [QUO_W];
    logic [DEN_W-1:0] den_in  [QUO_W];
    logic [QUO_W-1:0] quo_in  [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            logic [W-1:0] shifted;
            logic         fits;

            if (s == 0)
            begin : g_first
                assign rem_in[s] = W'(num);
                assign den_in[s] = den;
                assign quo_in[s] = '0;
            end
            else
            begin : g_rest
                assign rem_in[s] = rem_reg[s-1];
                assign den_in[s] = den_reg[s-1];
                assign quo_in[s] = quo_reg[s-1];
            end

            assign shifted = W'(den_in[s]) << (QUO_W - 1 - s);
            assign fits    = rem_in[s] >= shifted;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= fits ? rem_in[s] - shifted : rem_in[s];
                    den_reg[s] <= den_in[s];
                    quo_reg[s] <= quo_in[s] | (QUO_W'(fits) << (QUO_W - 1 - s));
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QUO_W-1];

endmodule

[rtl/core/positional_sound_pan_doppler_top.sv]
// top level: distance gain, stereo pan and doppler pitch for positional sound triggers
`timescale 1ns / 1ps

// Takes one sound trigger per clock while the output is not stalled and returns
// its result from the output register: stages 1 to 3 form the offsets, squares and
// dot products, a 25-stage square root gives the distance with eight fraction bits,
// the setup stage prepares the divisions, three 13-stage dividers run side by side
// for gain, pan and doppler, and volume and pitch are scaled into the output register.
// Triggers with id 255 or at or beyond their maximum distance give no result.
// Listener and axis registers must be written only while no trigger is in flight.
module positional_sound_pan_doppler_top
    import psp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        trig_valid,
    output logic        trig_stall,
    input  trig_t       trig,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    typedef struct packed {
        logic [8:0]                sound_id;
        logic [14:0]               volume;
        logic [15:0]               pitch;
        logic [MAXD_W-1:0]         maxd;
        logic                      dop;
        logic signed [15:0]        tag;
        logic signed [DOT_W-1:0]   f;
        logic signed [DOT_W-1:0]   s;
        logic signed [VDOT_W-1:0]  p;
        logic                      sq_nz;
    } mid_t;

    typedef struct packed {
        logic [8:0]         sound_id;
        logic [14:0]        volume;
        logic [15:0]        pitch;
        logic signed [15:0] tag;
        logic               dop_on;
        logic               p_neg;
        logic               sat;
        logic               use_div;
        logic [6:0]         pan_fixed;
    } post_t;

    logic signed [15:0] listener_x_reg, listener_y_reg, listener_z_reg;
    logic [47:0]        front_axis_reg, side_axis_reg;

    logic adv;

    // stage 1
    logic                  s1_valid_reg;
    trig_t                 s1_trig_reg;
    logic signed [D_W-1:0] s1_d_reg [3];
    logic signed [D_W-1:0] d_next   [3];

    // stage 2
    logic                    s2_valid_reg;
    trig_t                   s2_trig_reg;
    logic [SQP_W-1:0]        s2_sq_reg [3];
    logic signed [AXP_W-1:0] s2_fp_reg [3];
    logic signed [AXP_W-1:0] s2_sp_reg [3];
    logic signed [VP_W-1:0]  s2_vp_reg [3];
    logic signed [D_W+D_W-1:0] sqp_next [3];
    logic signed [AXP_W-1:0] fp_next [3];
    logic signed [AXP_W-1:0] sp_next [3];
    logic signed [VP_W-1:0]  vp_next [3];
    logic signed [31:0]      vel     [3];

    // stage 3
    logic             s3_valid_reg;
    mid_t             s3_mid_reg;
    logic [SQ_W-1:0]  s3_sq_reg;
    mid_t             mid_next;

    // square root and matching delay
    logic [D8_W-1:0] d8;
    logic            mid_valid;
    mid_t            mid;

    // setup stage
    logic                   pr_valid_reg;
    post_t                  pr_post_reg;
    logic [GAIN_NUM_W-1:0]  pr_gain_num_reg;
    logic [MAXD_W-1:0]      pr_gain_den_reg;
    logic [PAN_NUM_W-1:0]   pr_pan_num_reg;
    logic [ABS_W-1:0]       pr_pan_den_reg;
    logic [DOP_NUM_W-1:0]   pr_dop_num_reg;
    logic [DOP_DEN_W-1:0]   pr_dop_den_reg;

    logic [DIST_W-1:0]        dist_int;
    logic signed [DOT_W-1:0]  f_abs, s_abs;
    logic signed [DOT_W+7:0]  pan_num_s;
    logic signed [VDOT_W-1:0] p_abs;
    logic [DOP_DEN_W-1:0]     dop_den;
    logic [DOP_NUM_W-1:0]     dop_num;
    post_t                    post_next;

    // divider outputs
    logic [QUO_W-1:0] q_gain, q_pan, q_dop;
    logic             post_valid;
    post_t            post;

    // output
    logic              res_valid_reg;
    res_t              res_reg;
    logic [DELTA_W-1:0]  delta;
    logic [FACTOR_W-1:0] factor;
    logic [30:0]         pitch_prod;
    logic [8:0]          gain;
    logic [23:0]         vol_prod;
    res_t                res_next;

    assign adv        = !res_valid_reg || !res_stall;
    assign trig_stall = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_x_reg <= '0;
            listener_y_reg <= '0;
            listener_z_reg <= '0;
            front_axis_reg <= '0;
            side_axis_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LISTENER_X: listener_x_reg <= cfg_data[15:0];
                CFG_LISTENER_Y: listener_y_reg <= cfg_data[15:0];
                CFG_LISTENER_Z: listener_z_reg <= cfg_data[15:0];
                CFG_FRONT_AXIS: front_axis_reg <= cfg_data;
                CFG_SIDE_AXIS:  side_axis_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // stage 1: offsets to the listener
    always_comb
    begin
        d_next[0] = $signed({trig.src_x[15], trig.src_x})
                  - $signed({listener_x_reg[15], listener_x_reg});
        d_next[1] = $signed({trig.src_y[15], trig.src_y})
                  - $signed({listener_y_reg[15], listener_y_reg});
        d_next[2] = $signed({trig.src_z[15], trig.src_z})
                  - $signed({listener_z_reg[15], listener_z_reg});
    end

    // stage 2: squares and dot product terms
    always_comb
    begin
        vel[0] = s1_trig_reg.vel_x;
        vel[1] = s1_trig_reg.vel_y;
        vel[2] = s1_trig_reg.vel_z;
        for (int i = 0; i < 3; i++)
        begin
            sqp_next[i] = s1_d_reg[i] * s1_d_reg[i];
            fp_next[i]  = $signed(front_axis_reg[16*i +: 16]) * s1_d_reg[i];
            sp_next[i]  = $signed(side_axis_reg[16*i +: 16]) * s1_d_reg[i];
            vp_next[i]  = vel[i] * s1_d_reg[i];
        end
    end

    // stage 3: sums
    always_comb
    begin
        mid_next.sound_id = s2_trig_reg.sound_id;
        mid_next.volume   = s2_trig_reg.volume_in;
        mid_next.pitch    = s2_trig_reg.pitch_in;
        mid_next.maxd     = s2_trig_reg.max_distance;
        mid_next.dop      = s2_trig_reg.doppler_enable;
        mid_next.tag      = s2_trig_reg.priority_tag;
        mid_next.f        = DOT_W'(s2_fp_reg[0]) + DOT_W'(s2_fp_reg[1]) + DOT_W'(s2_fp_reg[2]);
        mid_next.s        = DOT_W'(s2_sp_reg[0]) + DOT_W'(s2_sp_reg[1]) + DOT_W'(s2_sp_reg[2]);
        mid_next.p        = VDOT_W'(s2_vp_reg[0]) + VDOT_W'(s2_vp_reg[1])
                          + VDOT_W'(s2_vp_reg[2]);
        mid_next.sq_nz    = (s2_sq_reg[0] | s2_sq_reg[1] | s2_sq_reg[2]) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= trig_valid && (trig.sound_id != NONE_ID);
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            pr_valid_reg <= mid_valid && (dist_int < DIST_W'(mid.maxd));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_trig_reg <= trig;
            s2_trig_reg <= s1_trig_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_d_reg[i]  <= d_next[i];
                s2_sq_reg[i] <= sqp_next[i][SQP_W-1:0];
                s2_fp_reg[i] <= fp_next[i];
                s2_sp_reg[i] <= sp_next[i];
                s2_vp_reg[i] <= vp_next[i];
            end
            s3_mid_reg <= mid_next;
            s3_sq_reg  <= SQ_W'(s2_sq_reg[0]) + SQ_W'(s2_sq_reg[1]) + SQ_W'(s2_sq_reg[2]);
        end
    end

    // distance with eight fraction bits; the integer distance is its upper part
    psp_isqrt #(
        .IN_W (RAD_W)
    ) u_isqrt (
        .clk      (clk),
        .en       (adv),
        .radicand ({s3_sq_reg, 16'd0}),
        .root     (d8)
    );

    psp_delay #(
        .WIDTH ($bits(mid_t)),
        .DEPTH (D8_W)
    ) u_mid_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid     (s3_valid_reg),
        .data      (s3_mid_reg),
        .valid_out (mid_valid),
        .data_out  (mid)
    );

    // setup stage: pan case, divider operands, doppler saturation
    always_comb
    begin
        dist_int  = d8[D8_W-1:8];
        f_abs     = mid.f[DOT_W-1] ? -mid.f : mid.f;
        s_abs     = mid.s[DOT_W-1] ? -mid.s : mid.s;
        pan_num_s = (DOT_W+8)'(mid.s) * 43'sd63 + (DOT_W+8)'(f_abs) * 43'sd64;
        p_abs     = mid.p[VDOT_W-1] ? -mid.p : mid.p;
        dop_den   = DOP_DEN_W'(d8) * DOP_SCALE;
        dop_num   = {p_abs[VMAG_W-1:0], 8'd0};

        post_next.sound_id = mid.sound_id;
        post_next.volume   = mid.volume;
        post_next.pitch    = mid.pitch;
        post_next.tag      = mid.tag;
        post_next.dop_on   = mid.dop && mid.sq_nz;
        post_next.p_neg    = mid.p[VDOT_W-1];
        // delta is clamped to half of unity once the quotient reaches it
        post_next.sat      = dop_num >= DOP_NUM_W'({dop_den, 13'd0});
        priority if (s_abs > f_abs)
        begin
            post_next.use_div   = 1'b0;
            post_next.pan_fixed = mid.s[DOT_W-1] ? PAN_LEFT : PAN_RIGHT;
        end
        else if (f_abs == '0)
        begin
            post_next.use_div   = 1'b0;
            post_next.pan_fixed = PAN_CENTER;
        end
        else
        begin
            post_next.use_div   = 1'b1;
            post_next.pan_fixed = PAN_CENTER;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_post_reg     <= post_next;
            pr_gain_num_reg <= {dist_int, 8'd0};
            pr_gain_den_reg <= mid.maxd;
            pr_pan_num_reg  <= pan_num_s[PAN_NUM_W-1:0];
            pr_pan_den_reg  <= f_abs[ABS_W-1:0];
            pr_dop_num_reg  <= dop_num;
            pr_dop_den_reg  <= dop_den;
        end
    end

    psp_udiv #(
        .NUM_W (GAIN_NUM_W),
        .DEN_W (MAXD_W),
        .QUO_W (QUO_W)
    ) u_div_gain (
        .clk (clk),
        .en  (adv),
        .num (pr_gain_num_reg),
        .den (pr_gain_den_reg),
        .quo (q_gain)
    );

    psp_udiv #(
        .NUM_W (PAN_NUM_W),
        .DEN_W (ABS_W),
        .QUO_W (QUO_W)
    ) u_div_pan (
        .clk (clk),
        .en  (adv),
        .num (pr_pan_num_reg),
        .den (pr_pan_den_reg),
        .quo (q_pan)
    );

    psp_udiv #(
        .NUM_W (DOP_NUM_W),
        .DEN_W (DOP_DEN_W),
        .QUO_W (QUO_W)
    ) u_div_dop (
        .clk (clk),
        .en  (adv),
        .num (pr_dop_num_reg),
        .den (pr_dop_den_reg),
        .quo (q_dop)
    );

    psp_delay #(
        .WIDTH ($bits(post_t)),
        .DEPTH (QUO_W)
    ) u_post_delay (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid     (pr_valid_reg),
        .data      (pr_post_reg),
        .valid_out (post_valid),
        .data_out  (post)
    );

    // final scaling
    always_comb
    begin
        delta = post.sat ? DELTA_MAX : DELTA_W'(q_dop);
        if (!post.dop_on)
        begin
            factor = FACTOR_ONE;
        end
        else if (post.p_neg)
        begin
            factor = FACTOR_ONE + FACTOR_W'(delta);
        end
        else
        begin
            factor = FACTOR_ONE - FACTOR_W'(delta);
        end
        pitch_prod = 31'(post.pitch) * 31'(factor);
        gain       = GAIN_FULL - 9'(q_gain[7:0]);
        vol_prod   = 24'(gain) * 24'(post.volume);

        res_next.sound_out  = post.sound_id;
        res_next.pan        = post.use_div ? q_pan[6:0] : post.pan_fixed;
        res_next.pitch_out  = pitch_prod[30] ? 16'hFFFF : pitch_prod[29:14];
        res_next.volume_out = vol_prod[22:8];
        res_next.tag_out    = post.tag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= post_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[verif/tb.sv]
// testbench for the positional sound pan and doppler block
`timescale 1ns / 1ps

module tb;
    import psp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RAND_PER_PHASE = 217;
    localparam int NUM_PHASES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        trig_valid = 1'b0;
    logic        trig_stall;
    trig_t       trig = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [47:0] cfg_data = 48'd0;

    // listener registers as the block should hold them
    logic signed [15:0] lst_x, lst_y, lst_z;
    logic [47:0]        front_ax, side_ax;

    trig_t pending_trigs[$];
    res_t  expected_res[$];
    res_t  accepted_res;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    errors = 0;
    int    cycles = 0;

    positional_sound_pan_doppler_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_valid (trig_valid),
        .trig_stall (trig_stall),
        .trig       (trig),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint axis_proj(input logic [47:0] ax, input longint ofs[3]);
        longint acc;
        acc = 0;
        for (int i = 0; i < 3; i++)
            acc += longint'($signed(ax[16*i +: 16])) * ofs[i];
        return acc;
    endfunction

    // distance gain, pan and doppler pitch; returns 0 when the trigger is dropped
    function automatic bit sound_mix(input trig_t t, output res_t r);
        longint ofs[3];
        longint vel[3];
        longint unsigned sq, dist_int, gain, pan, factor, pitch, mag, d8, delta;
        longint fr, sd, afr, asd, radial;
        r = '0;
        if (t.sound_id == NONE_ID)
            return 0;
        ofs[0] = longint'(t.src_x) - longint'(lst_x);
        ofs[1] = longint'(t.src_y) - longint'(lst_y);
        ofs[2] = longint'(t.src_z) - longint'(lst_z);
        vel[0] = longint'(t.vel_x);
        vel[1] = longint'(t.vel_y);
        vel[2] = longint'(t.vel_z);
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += longint'(ofs[i] * ofs[i]);
        dist_int = int_sqrt(sq);
        if (dist_int >= longint'(t.max_distance))
            return 0;
        gain = 256 - (dist_int * 256) / t.max_distance;

        fr = axis_proj(front_ax, ofs);
        sd = axis_proj(side_ax, ofs);
        afr = fr < 0 ? -fr : fr;
        asd = sd < 0 ? -sd : sd;
        if (asd > afr)
            pan = sd > 0 ? PAN_RIGHT : PAN_LEFT;
        else if (afr == 0)
            pan = PAN_CENTER;
        else
            pan = (63 * sd + 64 * afr) / afr;

        factor = FACTOR_ONE;
        if (t.doppler_enable && sq != 0)
        begin
            radial = 0;
            for (int i = 0; i < 3; i++)
                radial += ofs[i] * vel[i];
            mag = radial < 0 ? -radial : radial;
            d8 = int_sqrt(sq << 16);
            delta = (mag * 256) / (600 * d8);
            if (delta > DELTA_MAX)
                delta = DELTA_MAX;
            factor = radial >= 0 ? FACTOR_ONE - delta : FACTOR_ONE + delta;
        end
        pitch = (longint'(t.pitch_in) * factor) >> 14;
        if (pitch > 65535)
            pitch = 65535;

        r.sound_out = t.sound_id;
        r.pan = pan[6:0];
        r.pitch_out = pitch[15:0];
        r.volume_out = 15'((gain * t.volume_in) >> 8);
        r.tag_out = t.priority_tag;
        return 1;
    endfunction

    // trigger driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_valid <= 1'b0;
            trig <= '0;
        end
        else
        begin
            if (trig_valid && !trig_stall)
            begin
                if (sound_mix(trig, accepted_res))
                    expected_res.push_back(accepted_res);
            end
            if (!trig_valid || !trig_stall)
            begin
                if (pending_trigs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    trig <= pending_trigs.pop_front();
                    trig_valid <= 1'b1;
                end
                else
                    trig_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string nm, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, nm, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected transaction, actual %h", $time, res);
                    errors++;
                end
                else
                begin
                    accepted_res = expected_res.pop_front();
                    check_field("sound_out", accepted_res.sound_out, res.sound_out);
                    check_field("pan", accepted_res.pan, res.pan);
                    check_field("pitch_out", accepted_res.pitch_out, res.pitch_out);
                    check_field("volume_out", accepted_res.volume_out, res.volume_out);
                    check_field("tag_out", accepted_res.tag_out, res.tag_out);
                end
            end
            res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_LISTENER_X: lst_x = val[15:0];
            CFG_LISTENER_Y: lst_y = val[15:0];
            CFG_LISTENER_Z: lst_z = val[15:0];
            CFG_FRONT_AXIS: front_ax = val;
            CFG_SIDE_AXIS:  side_ax = val;
            default: ;
        endcase
    endtask

    task automatic set_listener(input logic [15:0] x, input logic [15:0] y,
                                input logic [15:0] z, input logic [47:0] fa,
                                input logic [47:0] sa);
        write_reg(CFG_LISTENER_X, {32'd0, x});
        write_reg(CFG_LISTENER_Y, {32'd0, y});
        write_reg(CFG_LISTENER_Z, {32'd0, z});
        write_reg(CFG_FRONT_AXIS, fa);
        write_reg(CFG_SIDE_AXIS, sa);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] near_coord(input logic signed [15:0] base,
                                                      input int span);
        int c;
        c = int'(base) + $urandom_range(0, 2 * span) - span;
        if (c > 32767)
            c = 32767;
        if (c < -32768)
            c = -32768;
        return c[15:0];
    endfunction

    function automatic trig_t random_trig();
        trig_t t;
        int    span;
        int    sel;
        t = '0;
        t.sound_id = ($urandom_range(0, 19) == 0) ? NONE_ID : 9'($urandom);
        t.volume_in = 15'($urandom);
        t.pitch_in = 16'($urandom);
        sel = $urandom_range(0, 3);
        span = sel == 0 ? 8 : sel == 1 ? 200 : sel == 2 ? 3000 : 32767;
        if ($urandom_range(0, 9) < 8)
        begin
            t.src_x = near_coord(lst_x, span);
            t.src_y = near_coord(lst_y, span);
            t.src_z = near_coord(lst_z, span);
        end
        else
        begin
            t.src_x = 16'($urandom);
            t.src_y = 16'($urandom);
            t.src_z = 16'($urandom);
        end
        if ($urandom_range(0, 1))
        begin
            t.vel_x = $urandom;
            t.vel_y = $urandom;
            t.vel_z = $urandom;
        end
        else
        begin
            t.vel_x = $urandom_range(0, 2 ** 21) - 2 ** 20;
            t.vel_y = $urandom_range(0, 2 ** 21) - 2 ** 20;
            t.vel_z = $urandom_range(0, 2 ** 21) - 2 ** 20;
        end
        t.max_distance = ($urandom_range(0, 49) == 0) ? 15'd0 : 15'($urandom_range(1, 32767));
        t.doppler_enable = 1'($urandom);
        t.priority_tag = 16'($urandom);
        return t;
    endfunction

    task automatic push_directed(input logic [8:0] id, input logic [14:0] vol,
                                 input logic [15:0] pitch, input int x, input int y,
                                 input int z, input logic [31:0] vx, input logic [31:0] vy,
                                 input logic [14:0] maxd, input logic dop);
        trig_t t;
        t.sound_id = id;
        t.volume_in = vol;
        t.pitch_in = pitch;
        t.src_x = x[15:0];
        t.src_y = y[15:0];
        t.src_z = z[15:0];
        t.vel_x = vx;
        t.vel_y = vy;
        t.vel_z = 32'd0;
        t.max_distance = maxd;
        t.doppler_enable = dop;
        t.priority_tag = 16'($urandom);
        pending_trigs.push_back(t);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_trigs.size() != 0 || trig_valid || expected_res.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        lst_x = 0;
        lst_y = 0;
        lst_z = 0;
        front_ax = '0;
        side_ax = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset listener, zero axes
        push_directed(9'd1, 15'd1000, 16'd4096, 0, 0, 0, 32'd65536, 32'd0, 15'd10, 1'b1);
        push_directed(NONE_ID, 15'd32767, 16'd4096, 1, 0, 0, 32'd0, 32'd0, 15'd100, 1'b0);
        push_directed(9'd511, 15'd32767, 16'hFFFF, 3, 4, 0, 32'd0, 32'd0, 15'd100, 1'b1);
        push_directed(9'd2, 15'd500, 16'd4096, 0, 0, 0, 32'd0, 32'd0, 15'd0, 1'b1);
        push_directed(9'd3, 15'd500, 16'd4096, 0, 0, 0, 32'd0, 32'd0, 15'd1, 1'b1);
        push_directed(9'd4, 15'd500, 16'd4096, 100, 0, 0, 32'd0, 32'd0, 15'd100, 1'b1);
        push_directed(9'd5, 15'd32767, 16'd4096, 99, 0, 0, 32'd0, 32'd0, 15'd100, 1'b1);
        push_directed(9'd6, 15'd32767, 16'd4096, -32768, -32768, -32768,
                      32'd0, 32'd0, 15'd32767, 1'b1);
        push_directed(9'd7, 15'd32767, 16'd4096, 32767, 0, 0, 32'd0, 32'd0, 15'd32767, 1'b1);
        push_directed(9'd8, 15'd32767, 16'hFFFF, 20000, 0, 0, 32'h8000_0000, 32'd0,
                      15'd32767, 1'b1);
        push_directed(9'd9, 15'd32767, 16'hFFFF, 20000, 0, 0, 32'h7FFF_FFFF, 32'd0,
                      15'd32767, 1'b1);
        push_directed(9'd10, 15'd32767, 16'hFFFF, 20000, 0, 0, 32'h7FFF_FFFF, 32'd0,
                      15'd32767, 1'b0);
        push_directed(9'd11, 15'd0, 16'd0, -5, 7, 0, 32'hFFF0_0000, 32'h0010_0000,
                      15'd32767, 1'b1);
        push_directed(9'd12, 15'd12345, 16'd8192, 1, 1, 0, 32'd0, 32'd0, 15'd2, 1'b1);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: ;
                1: set_listener(16'd0, 16'd0, 16'd0, 48'h0000_0000_4000, 48'h0000_4000_0000);
                2: set_listener(16'h7FFF, 16'h7FFF, 16'h7FFF, 48'hFFFF_FFFF_FFFF,
                                48'h7FFF_8000_7FFF);
                3: set_listener(16'h8000, 16'h8000, 16'h8000, 48'h8000_8000_8000,
                                48'h7FFF_7FFF_7FFF);
                default: set_listener(16'($urandom), 16'($urandom), 16'($urandom),
                                      {16'($urandom), 32'($urandom)},
                                      {16'($urandom), 32'($urandom)});
            endcase
            send_idle_pct = (ph % 4 == 1) ? 60 : (ph % 4 == 3) ? 29 : 0;
            stall_pct = (ph % 4 == 2) ? 60 : (ph % 4 == 3) ? 29 : 0;
            for (int i = 0; i < RAND_PER_PHASE; i++)
                pending_trigs.push_back(random_trig());
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
